### src/bitmask_dictionary_code_compressor_top_assert.svh
// Assertion macros shared by the compressor modules.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BITMASK_DICTIONARY_CODE_COMPRESSOR_TOP_ASSERT_SVH
`define BITMASK_DICTIONARY_CODE_COMPRESSOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BDCC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BDCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bdcc_pkg.sv
// ----------------------------------------------------------------------------
// bdcc_pkg
// Shared types and codes of the bitmask dictionary code compressor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdcc_pkg;

    localparam int WORD_W   = 32;
    localparam int CODE_W   = 35;
    localparam int LEN_W    = 6;
    localparam int FMT_W    = 3;
    localparam int IDXF_W   = 4;
    localparam int POS_W    = 5;
    localparam int MASK_W   = 4;
    localparam int REQ_W    = 2;

    // request types
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

    // format codes
    localparam logic [FMT_W-1:0] FMT_RAW      = 3'b000;
    localparam logic [FMT_W-1:0] FMT_RUN      = 3'b001;
    localparam logic [FMT_W-1:0] FMT_BITMASK  = 3'b010;
    localparam logic [FMT_W-1:0] FMT_ONE      = 3'b011;
    localparam logic [FMT_W-1:0] FMT_TWO_ADJ  = 3'b100;
    localparam logic [FMT_W-1:0] FMT_FOUR_ADJ = 3'b101;
    localparam logic [FMT_W-1:0] FMT_TWO_ANY  = 3'b110;
    localparam logic [FMT_W-1:0] FMT_DIRECT   = 3'b111;

    // code lengths
    localparam logic [LEN_W-1:0] LEN_RAW     = 6'd35;
    localparam logic [LEN_W-1:0] LEN_RUN     = 6'd6;
    localparam logic [LEN_W-1:0] LEN_BITMASK = 6'd16;
    localparam logic [LEN_W-1:0] LEN_POS     = 6'd12;
    localparam logic [LEN_W-1:0] LEN_TWO_ANY = 6'd17;
    localparam logic [LEN_W-1:0] LEN_DIRECT  = 6'd7;

    // match kinds, in priority order
    localparam int KIND_DIRECT   = 0;
    localparam int KIND_ONE      = 1;
    localparam int KIND_TWO_ADJ  = 2;
    localparam int KIND_FOUR_ADJ = 3;
    localparam int KIND_BITMASK  = 4;
    localparam int KIND_TWO_ANY  = 5;
    localparam int NUM_KINDS     = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN_OUT,
        ST_SCAN,
        ST_DRAIN,
        ST_CODE_OUT
    } t_state;

    typedef struct packed {
        logic              accept;
        logic              scan_issue;
        logic [IDXF_W-1:0] scan_addr;
        logic              load_run;
        logic              run_last;
        logic              load_code;
    } t_dp_cmd;

    typedef struct packed {
        logic need_run;
        logic absorb;
        logic run_pending;
        logic pipe_busy;
        logic slot_free;
    } t_dp_sts;

    typedef struct packed {
        logic [IDXF_W-1:0] idx;
        logic [POS_W-1:0]  top;
        logic [POS_W-1:0]  low;
    } t_hit;

endpackage

### src/bdcc_ram.sv
// ----------------------------------------------------------------------------
// bdcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/bdcc_dp.sv
// ----------------------------------------------------------------------------
// bdcc_dp
// Datapath: dictionary store, run state, match pipeline, code build and
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmask_dictionary_code_compressor_top_assert.svh"

module bdcc_dp #(
    parameter int DICT_ENTRIES = 16,
    parameter int MAX_RUN      = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bdcc_pkg::t_dp_cmd                 i_cmd,
    output bdcc_pkg::t_dp_sts                 o_sts,
    input  logic [bdcc_pkg::REQ_W-1:0]        i_req_type,
    input  logic [bdcc_pkg::IDXF_W-1:0]       i_dict_index,
    input  logic [bdcc_pkg::WORD_W-1:0]       i_data_word,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [bdcc_pkg::CODE_W-1:0]       o_code_bits,
    output logic [bdcc_pkg::LEN_W-1:0]        o_code_length,
    output logic [bdcc_pkg::FMT_W-1:0]        o_code_format,
    output logic                              o_last_code
);

    localparam int IDX_W = $clog2(DICT_ENTRIES);
    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int WW    = bdcc_pkg::WORD_W;
    localparam int PW    = bdcc_pkg::POS_W;

    // run state
    logic [WW-1:0]    r_prev_word;
    logic             r_prev_valid;
    logic [CNT_W-1:0] r_repeat_count;
    logic [WW-1:0]    r_word;
    logic [DICT_ENTRIES-1:0] r_entry_valid;

    logic same_word, absorb, need_run, index_ok, dict_we, enc_accept;
    logic [WW-1:0] ram_rdata;

    // match pipeline
    logic              r_p1_busy, r_p1_ev, r_p2_busy, r_p2_ev;
    logic [IDX_W-1:0]  r_p1_idx, r_p2_idx;
    logic [WW-1:0]     r_x;

    logic [PW-1:0] top_pos, low_pos, span;
    logic [WW-1:0] y1, y2;
    logic          nz, four_run;
    logic [bdcc_pkg::NUM_KINDS-1:0] cond;

    logic [bdcc_pkg::NUM_KINDS-1:0] r_hit;
    bdcc_pkg::t_hit                 r_hit_info [bdcc_pkg::NUM_KINDS];
    logic [WW-1:0]                  r_bm_x;

    // code build
    logic [bdcc_pkg::CODE_W-1:0] code_bits;
    logic [bdcc_pkg::LEN_W-1:0]  code_len;
    logic [bdcc_pkg::FMT_W-1:0]  code_fmt;
    logic [CNT_W-1:0]            run_minus;
    logic [PW-1:0]               pos_a, pos_b;
    logic [bdcc_pkg::MASK_W-1:0] bm_mask;
    bdcc_pkg::t_hit              hi;

    // output register
    logic                        r_out_valid, r_out_last;
    logic [bdcc_pkg::CODE_W-1:0] r_out_bits;
    logic [bdcc_pkg::LEN_W-1:0]  r_out_len;
    logic [bdcc_pkg::FMT_W-1:0]  r_out_fmt;
    logic                        slot_free;

    assign enc_accept = i_cmd.accept && (i_req_type == bdcc_pkg::REQ_ENCODE);
    assign same_word  = r_prev_valid && (i_data_word == r_prev_word);
    assign absorb     = same_word && (r_repeat_count < CNT_W'(MAX_RUN));
    assign need_run   = (r_repeat_count >= CNT_W'(MAX_RUN)) ||
                        ((r_repeat_count != '0) && !same_word);
    assign index_ok   = ({1'b0, i_dict_index} < (bdcc_pkg::IDXF_W + 1)'(DICT_ENTRIES));
    assign dict_we    = i_cmd.accept && (i_req_type == bdcc_pkg::REQ_LOAD) && index_ok;
    assign slot_free  = !r_out_valid || i_out_ready;

    assign o_sts.need_run    = need_run;
    assign o_sts.absorb      = absorb;
    assign o_sts.run_pending = (r_repeat_count != '0);
    assign o_sts.pipe_busy   = r_p1_busy || r_p2_busy;
    assign o_sts.slot_free   = slot_free;

    bdcc_ram #(
        .WIDTH (WW),
        .DEPTH (DICT_ENTRIES)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (dict_we),
        .i_waddr (i_dict_index[IDX_W-1:0]),
        .i_wdata (i_data_word),
        .i_raddr (i_cmd.scan_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // valid bits, run state and captured word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid  <= '0;
            r_prev_word    <= '0;
            r_prev_valid   <= 1'b0;
            r_repeat_count <= '0;
        end else begin
            if (dict_we) begin
                r_entry_valid[i_dict_index[IDX_W-1:0]] <= 1'b1;
            end
            if (enc_accept) begin
                r_prev_word  <= i_data_word;
                r_prev_valid <= 1'b1;
                if (absorb) begin
                    r_repeat_count <= r_repeat_count + 1'b1;
                end
            end
            if (i_cmd.load_run) begin
                r_repeat_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enc_accept) begin
            r_word <= i_data_word;
        end
    end

    // two pipeline stages behind the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_busy <= 1'b0;
            r_p2_busy <= 1'b0;
        end else begin
            r_p1_busy <= i_cmd.scan_issue;
            r_p2_busy <= r_p1_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_ev  <= r_entry_valid[i_cmd.scan_addr[IDX_W-1:0]];
        r_p1_idx <= i_cmd.scan_addr[IDX_W-1:0];
        r_p2_ev  <= r_p1_ev;
        r_p2_idx <= r_p1_idx;
        r_x      <= r_word ^ ram_rdata;
    end

    // classify the difference word of one entry
    always_comb begin
        top_pos = '0;
        low_pos = '0;
        for (int i = 0; i < WW; i++) begin
            if (r_x[i]) top_pos = PW'(i);
        end
        for (int i = WW - 1; i >= 0; i--) begin
            if (r_x[i]) low_pos = PW'(i);
        end
    end

    assign nz       = |r_x;
    assign span     = top_pos - low_pos;
    assign four_run = |(r_x & (r_x >> 1) & (r_x >> 2) & (r_x >> 3));
    assign y1       = r_x & (r_x - 1'b1);
    assign y2       = y1 & (y1 - 1'b1);

    always_comb begin
        cond = '0;
        cond[bdcc_pkg::KIND_DIRECT]   = !nz;
        cond[bdcc_pkg::KIND_ONE]      = nz && (span == PW'(0));
        cond[bdcc_pkg::KIND_TWO_ADJ]  = nz && (span == PW'(1));
        cond[bdcc_pkg::KIND_FOUR_ADJ] = nz && (span == PW'(3)) && four_run;
        cond[bdcc_pkg::KIND_BITMASK]  = nz && (top_pos >= PW'(3)) && (span <= PW'(3));
        cond[bdcc_pkg::KIND_TWO_ANY]  = (y1 != '0) && (y2 == '0);
    end

    // keep the first entry that hits each kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= '0;
        end else if (enc_accept) begin
            r_hit <= '0;
        end else if (r_p2_busy && r_p2_ev) begin
            r_hit <= r_hit | cond;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bdcc_pkg::NUM_KINDS; k++) begin
            if (r_p2_busy && r_p2_ev && cond[k] && !r_hit[k]) begin
                r_hit_info[k] <= '{idx: bdcc_pkg::IDXF_W'(r_p2_idx), top: top_pos,
                                   low: low_pos};
            end
        end
        if (r_p2_busy && r_p2_ev && cond[bdcc_pkg::KIND_BITMASK] &&
            !r_hit[bdcc_pkg::KIND_BITMASK]) begin
            r_bm_x <= r_x;
        end
    end

    // build the code of the best kind, or a raw code when no kind hit
    always_comb begin
        hi        = r_hit_info[bdcc_pkg::KIND_DIRECT];
        code_bits = bdcc_pkg::CODE_W'(r_word);
        code_len  = bdcc_pkg::LEN_RAW;
        code_fmt  = bdcc_pkg::FMT_RAW;
        if (r_hit[bdcc_pkg::KIND_DIRECT]) begin
            hi = r_hit_info[bdcc_pkg::KIND_DIRECT];
        end else if (r_hit[bdcc_pkg::KIND_ONE]) begin
            hi = r_hit_info[bdcc_pkg::KIND_ONE];
        end else if (r_hit[bdcc_pkg::KIND_TWO_ADJ]) begin
            hi = r_hit_info[bdcc_pkg::KIND_TWO_ADJ];
        end else if (r_hit[bdcc_pkg::KIND_FOUR_ADJ]) begin
            hi = r_hit_info[bdcc_pkg::KIND_FOUR_ADJ];
        end else if (r_hit[bdcc_pkg::KIND_BITMASK]) begin
            hi = r_hit_info[bdcc_pkg::KIND_BITMASK];
        end else if (r_hit[bdcc_pkg::KIND_TWO_ANY]) begin
            hi = r_hit_info[bdcc_pkg::KIND_TWO_ANY];
        end
        pos_a   = PW'(31) - hi.top;
        pos_b   = PW'(31) - hi.low;
        bm_mask = bdcc_pkg::MASK_W'(r_bm_x >> (hi.top - PW'(3)));
        if (r_hit[bdcc_pkg::KIND_DIRECT]) begin
            code_bits = bdcc_pkg::CODE_W'({bdcc_pkg::FMT_DIRECT, hi.idx});
            code_len  = bdcc_pkg::LEN_DIRECT;
            code_fmt  = bdcc_pkg::FMT_DIRECT;
        end else if (r_hit[bdcc_pkg::KIND_ONE]) begin
            code_bits = bdcc_pkg::CODE_W'({bdcc_pkg::FMT_ONE, pos_a, hi.idx});
            code_len  = bdcc_pkg::LEN_POS;
            code_fmt  = bdcc_pkg::FMT_ONE;
        end else if (r_hit[bdcc_pkg::KIND_TWO_ADJ]) begin
            code_bits = bdcc_pkg::CODE_W'({bdcc_pkg::FMT_TWO_ADJ, pos_a, hi.idx});
            code_len  = bdcc_pkg::LEN_POS;
            code_fmt  = bdcc_pkg::FMT_TWO_ADJ;
        end else if (r_hit[bdcc_pkg::KIND_FOUR_ADJ]) begin
            code_bits = bdcc_pkg::CODE_W'({bdcc_pkg::FMT_FOUR_ADJ, pos_a, hi.idx});
            code_len  = bdcc_pkg::LEN_POS;
            code_fmt  = bdcc_pkg::FMT_FOUR_ADJ;
        end else if (r_hit[bdcc_pkg::KIND_BITMASK]) begin
            code_bits = bdcc_pkg::CODE_W'({bdcc_pkg::FMT_BITMASK, pos_a, bm_mask, hi.idx});
            code_len  = bdcc_pkg::LEN_BITMASK;
            code_fmt  = bdcc_pkg::FMT_BITMASK;
        end else if (r_hit[bdcc_pkg::KIND_TWO_ANY]) begin
            code_bits = bdcc_pkg::CODE_W'({bdcc_pkg::FMT_TWO_ANY, pos_a, pos_b, hi.idx});
            code_len  = bdcc_pkg::LEN_TWO_ANY;
            code_fmt  = bdcc_pkg::FMT_TWO_ANY;
        end
    end

    assign run_minus = r_repeat_count - 1'b1;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_run || i_cmd.load_code) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_run) begin
            r_out_bits <= bdcc_pkg::CODE_W'({bdcc_pkg::FMT_RUN, 3'(run_minus)});
            r_out_len  <= bdcc_pkg::LEN_RUN;
            r_out_fmt  <= bdcc_pkg::FMT_RUN;
            r_out_last <= i_cmd.run_last;
        end else if (i_cmd.load_code) begin
            r_out_bits <= code_bits;
            r_out_len  <= code_len;
            r_out_fmt  <= code_fmt;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_bits   = r_out_bits;
    assign o_code_length = r_out_len;
    assign o_code_format = r_out_fmt;
    assign o_last_code   = r_out_last;

    `BDCC_ASSERT_SAME(a_run_has_count, i_cmd.load_run, r_repeat_count != '0,
        "run code sent with no repeats pending")
    `BDCC_ASSERT_SAME(a_code_after_drain, i_cmd.load_code, !(r_p1_busy || r_p2_busy),
        "code built before the match pipeline drained")
    `BDCC_ASSERT_SAME(a_load_free_slot, i_cmd.load_run || i_cmd.load_code, slot_free,
        "result written over an untaken result")
    `BDCC_ASSERT_NEXT(a_absorb_bounded, enc_accept && absorb,
        (r_repeat_count != '0) && (r_repeat_count <= CNT_W'(MAX_RUN)),
        "repeat count out of range after a repeat")

endmodule

### src/bdcc_ctrl.sv
// ----------------------------------------------------------------------------
// bdcc_ctrl
// Controller: request decode, run emission, dictionary scan and code emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmask_dictionary_code_compressor_top_assert.svh"

module bdcc_ctrl #(
    parameter int DICT_ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [bdcc_pkg::REQ_W-1:0] i_req_type,
    output logic                       o_in_ready,
    input  bdcc_pkg::t_dp_sts          i_sts,
    output bdcc_pkg::t_dp_cmd          o_cmd
);

    localparam int IDX_W = $clog2(DICT_ENTRIES);

    bdcc_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_scan, n_scan;
    logic             r_flush, n_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdcc_pkg::ST_IDLE;
            r_scan  <= '0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_flush <= n_flush;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_scan     = r_scan;
        n_flush    = r_flush;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bdcc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        bdcc_pkg::REQ_ENCODE: begin
                            if (i_sts.absorb) begin
                                n_state = bdcc_pkg::ST_IDLE;
                            end else if (i_sts.need_run) begin
                                n_flush = 1'b0;
                                n_state = bdcc_pkg::ST_RUN_OUT;
                            end else begin
                                n_scan  = '0;
                                n_state = bdcc_pkg::ST_SCAN;
                            end
                        end
                        bdcc_pkg::REQ_FLUSH: begin
                            if (i_sts.run_pending) begin
                                n_flush = 1'b1;
                                n_state = bdcc_pkg::ST_RUN_OUT;
                            end
                        end
                        default: begin
                            n_state = bdcc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bdcc_pkg::ST_RUN_OUT: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_run = 1'b1;
                    o_cmd.run_last = r_flush;
                    if (r_flush) begin
                        n_state = bdcc_pkg::ST_IDLE;
                    end else begin
                        n_scan  = '0;
                        n_state = bdcc_pkg::ST_SCAN;
                    end
                end
            end
            bdcc_pkg::ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                o_cmd.scan_addr  = bdcc_pkg::IDXF_W'(r_scan);
                if (r_scan == IDX_W'(DICT_ENTRIES - 1)) begin
                    n_state = bdcc_pkg::ST_DRAIN;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            bdcc_pkg::ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = bdcc_pkg::ST_CODE_OUT;
                end
            end
            bdcc_pkg::ST_CODE_OUT: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_code = 1'b1;
                    n_state         = bdcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bdcc_pkg::ST_IDLE;
            end
        endcase
    end

    `BDCC_ASSERT_NEXT(a_absorb_stays_idle,
        o_cmd.accept && (i_req_type == bdcc_pkg::REQ_ENCODE) && i_sts.absorb,
        o_in_ready, "repeated word left the idle state")

endmodule

### src/bitmask_dictionary_code_compressor_top.sv
// ----------------------------------------------------------------------------
// bitmask_dictionary_code_compressor_top
// Load and repeated-word requests give no result; a flush gives a run code only when one is pending.
// Encode: the code is written to the output register after the scan of all entries and the
// match pipeline drain, a pending run code going first; a new request is taken only once
// the code is written, since the scan reads one entry per cycle from the RAM port.
// Reset clears valid bits, run state and control; the dictionary RAM keeps data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Compresses 32-bit words against a small dictionary.
//
// Request flow (one request at a time):
//  - load:   write the entry into the dictionary RAM and set its valid bit.
//  - encode: a repeat of the previous word only bumps the run count while it is below
//            MAX_RUN. Any other word first drops a pending run code into the output
//            register, then scans every entry, one per cycle, through a two-stage match
//            pipeline that keeps the first hitting entry of each code kind.
//            After the pipeline drains the best kind is built into a code.
//  - flush:  send the pending run code, if any.
//
// The output register parts the two sides: a new request is taken while a
// result still waits downstream, and the controller holds only when it has a
// second result to write into a full register.

module bitmask_dictionary_code_compressor_top #(
    parameter int DICT_ENTRIES = 16,
    parameter int MAX_RUN      = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [3:0] dict_index, [35:4] data_word, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // code channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [34:0] code_bits, [40:35] code_length, rest zero
    output logic [2:0]  m_axis_tuser,   // [2:0] code_format
    output logic        m_axis_tlast    // last_code
);

    bdcc_pkg::t_dp_cmd cmd;
    bdcc_pkg::t_dp_sts sts;

    logic [bdcc_pkg::CODE_W-1:0] code_bits;
    logic [bdcc_pkg::LEN_W-1:0]  code_length;

    // sequence requests and results
    bdcc_ctrl #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // dictionary, match pipeline and output register
    bdcc_dp #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .MAX_RUN      (MAX_RUN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (s_axis_tuser),
        .i_dict_index  (s_axis_tdata[3:0]),
        .i_data_word   (s_axis_tdata[35:4]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_code_bits   (code_bits),
        .o_code_length (code_length),
        .o_code_format (m_axis_tuser),
        .o_last_code   (m_axis_tlast)
    );

    // pack the result, zero padding at the top
    assign m_axis_tdata = {7'd0, code_length, code_bits};

endmodule
